/* rtl/rti_pkg.sv */
// Shared types, constants and saturating helpers for the ray/triangle intersection block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package rti_pkg;

	localparam int WORD_W     = 64;
	localparam int DIST_W     = 31;
	localparam int TOL_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int FIFO_DEPTH = 4;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [WORD_W:0]   wide_t;
	typedef word_t [2:0]              vec3_t;

	localparam word_t WMAX     = {1'b0, {(WORD_W-1){1'b1}}};
	localparam wide_t WIDE_MAX = wide_t'(WMAX);
	localparam wide_t WIDE_MIN = -WIDE_MAX;
	localparam word_t DIST_MAX = word_t'({DIST_W{1'b1}});

	typedef enum logic [2:0] {
		RSN_HIT      = 3'd0,
		RSN_PARALLEL = 3'd1,
		RSN_BEHIND   = 3'd2,
		RSN_DEGEN    = 3'd3,
		RSN_OUTSIDE  = 3'd4
	} reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORG_X = 3'd0,
		REG_ORG_Y = 3'd1,
		REG_ORG_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5,
		REG_TOL   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		vec3_t org;
		vec3_t dir;
		word_t tol;
	} ray_t;

	typedef struct packed {
		vec3_t v0;
		vec3_t v1;
		vec3_t v2;
		vec3_t n;
	} tri_t;

	typedef struct packed {
		vec3_t v0;
		vec3_t u;
		vec3_t v;
		vec3_t n;
		vec3_t tmp;
	} entry_t;

	typedef struct packed {
		vec3_t v0;
		vec3_t u;
		vec3_t v;
		vec3_t p;
		vec3_t w;
		word_t den;
		word_t num;
		word_t uv;
		word_t vv;
		word_t uu;
		word_t r;
		word_t d;
		word_t wv;
		word_t wu;
		word_t snum;
		word_t tnum;
		logic  par;
		logic  beh;
		logic  deg;
	} ctx_t;

	// Sum clamped to the symmetric range [-WMAX, WMAX].
	function automatic word_t sadd(word_t a, word_t b);
		wide_t s;
		s = wide_t'(a) + wide_t'(b);
		if (s > WIDE_MAX)
			return WMAX;
		else if (s < WIDE_MIN)
			return -WMAX;
		else
			return word_t'(s);
	endfunction

	function automatic word_t ssub(word_t a, word_t b);
		return sadd(a, -b);
	endfunction

	function automatic word_t sum3(word_t a, word_t b, word_t c);
		return sadd(sadd(a, b), c);
	endfunction

	function automatic logic [WORD_W-1:0] umag(word_t a);
		return a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
	endfunction

endpackage
`default_nettype wire

/* rtl/rti_qmul.sv */
// Lanes of fixed point multipliers, (a*b) >> FRAC_BITS, truncated and saturated, two stages.
// Depends on rti_pkg. A side word and a valid bit travel alongside.
`default_nettype none
module rti_qmul #(
	parameter int LANES     = 1,
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 vld_in,
	input  wire rti_pkg::word_t [LANES-1:0]           a,
	input  wire rti_pkg::word_t [LANES-1:0]           b,
	input  wire logic [SIDE_W-1:0]                    side_in,
	output logic                                      vld_out,
	output rti_pkg::word_t [LANES-1:0]                p,
	output logic [SIDE_W-1:0]                         side_out
);
	import rti_pkg::*;

	localparam int HALF   = WORD_W / 2;
	localparam int FULL_W = 2 * WORD_W;

	logic              vld_s1, vld_s2;
	logic [SIDE_W-1:0] side_s1, side_s2;
	word_t [LANES-1:0] p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [WORD_W-1:0] xm, ym;
		logic [WORD_W-1:0] p00_s1, p01_s1, p10_s1, p11_s1;
		logic              neg_s1;
		logic [FULL_W-1:0] full, q;
		word_t             mag;

		assign xm = umag(a[l]);
		assign ym = umag(b[l]);

		// Four half-width partial products per lane.
		always_ff @(posedge clk) begin
			if (en) begin
				p00_s1 <= xm[HALF-1:0] * ym[HALF-1:0];
				p01_s1 <= xm[HALF-1:0] * ym[WORD_W-1:HALF];
				p10_s1 <= xm[WORD_W-1:HALF] * ym[HALF-1:0];
				p11_s1 <= xm[WORD_W-1:HALF] * ym[WORD_W-1:HALF];
				neg_s1 <= a[l][WORD_W-1] ^ b[l][WORD_W-1];
			end
		end

		always_comb begin
			full = FULL_W'(p00_s1) + (FULL_W'(p01_s1) << HALF) + (FULL_W'(p10_s1) << HALF)
				+ (FULL_W'(p11_s1) << WORD_W);
			q    = full >> FRAC_BITS;
			mag  = (|q[FULL_W-1:WORD_W-1]) ? WMAX : word_t'(q[WORD_W-1:0]);
		end

		always_ff @(posedge clk) begin
			if (en)
				p_s2[l] <= neg_s1 ? -mag : mag;
		end
	end

	assign vld_out  = vld_s2;
	assign p        = p_s2;
	assign side_out = side_s2;

endmodule
`default_nettype wire

/* rtl/rti_qdiv.sv */
// Lanes of pipelined restoring dividers, (a << FRAC_BITS) / b, truncated and saturated.
// Depends on rti_pkg. One quotient bit per stage, between an input and an output register.
`default_nettype none
module rti_qdiv #(
	parameter int LANES     = 1,
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 vld_in,
	input  wire rti_pkg::word_t [LANES-1:0]           a,
	input  wire rti_pkg::word_t [LANES-1:0]           b,
	input  wire logic [SIDE_W-1:0]                    side_in,
	output logic                                      vld_out,
	output rti_pkg::word_t [LANES-1:0]                q,
	output logic [SIDE_W-1:0]                         side_out
);
	import rti_pkg::*;

	// Dividend bits above WORD_W + FRAC_BITS are always zero, so those steps are skipped.
	localparam int ITER = WORD_W + FRAC_BITS;

	logic [WORD_W-1:0] rem_s [ITER+1][LANES];
	logic [WORD_W-2:0] quo_s [ITER+1][LANES];
	logic              ovf_s [ITER+1][LANES];
	logic [WORD_W-1:0] x_s   [ITER+1][LANES];
	logic [WORD_W-1:0] y_s   [ITER+1][LANES];
	logic              neg_s [ITER+1][LANES];
	logic              vld_s [ITER+1];
	logic [SIDE_W-1:0] side_s [ITER+1];

	logic              vld_o_s;
	logic [SIDE_W-1:0] side_o_s;
	word_t [LANES-1:0] q_o_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			vld_o_s  <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			vld_o_s  <= vld_s[ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			side_o_s  <= side_s[ITER];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_entry
		word_t mag;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l] <= '0;
				quo_s[0][l] <= '0;
				ovf_s[0][l] <= 1'b0;
				x_s[0][l]   <= umag(a[l]);
				y_s[0][l]   <= umag(b[l]);
				neg_s[0][l] <= a[l][WORD_W-1] ^ b[l][WORD_W-1];
			end
		end

		assign mag = ovf_s[ITER][l] ? WMAX : word_t'({1'b0, quo_s[ITER][l]});

		always_ff @(posedge clk) begin
			if (en)
				q_o_s[l] <= neg_s[ITER][l] ? -mag : mag;
		end
	end

	for (genvar k = 0; k < ITER; k++) begin : g_stage
		localparam int BIT = ITER - 1 - k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en)
				side_s[k+1] <= side_s[k];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic              nb, ge, ovf_nx;
			logic [WORD_W:0]   r65, dif;
			logic [WORD_W-2:0] quo_nx;

			if (BIT >= FRAC_BITS) begin : g_bit
				assign nb = x_s[k][l][BIT-FRAC_BITS];
			end else begin : g_zero
				assign nb = 1'b0;
			end

			assign r65 = {rem_s[k][l], nb};
			assign dif = r65 - {1'b0, y_s[k][l]};
			assign ge  = r65 >= {1'b0, y_s[k][l]};

			// Quotient bits at or above the sign position only mark an overflow.
			if (BIT >= WORD_W - 1) begin : g_ovf
				assign ovf_nx = ovf_s[k][l] | ge;
				assign quo_nx = quo_s[k][l];
			end else begin : g_quo
				assign ovf_nx = ovf_s[k][l];
				always_comb begin
					quo_nx      = quo_s[k][l];
					quo_nx[BIT] = ge;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l] <= ge ? dif[WORD_W-1:0] : r65[WORD_W-1:0];
					quo_s[k+1][l] <= quo_nx;
					ovf_s[k+1][l] <= ovf_nx;
					x_s[k+1][l]   <= x_s[k][l];
					y_s[k+1][l]   <= y_s[k][l];
					neg_s[k+1][l] <= neg_s[k][l];
				end
			end
		end
	end

	assign vld_out  = vld_o_s;
	assign q        = q_o_s;
	assign side_out = side_o_s;

endmodule
`default_nettype wire

/* rtl/rti_front.sv */
// Front end: accepts triangles, forms the edge and origin differences, queues them.
// Depends on rti_pkg.
`default_nettype none
module rti_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire rti_pkg::tri_t   tri_in,
	input  wire rti_pkg::ray_t   ray,
	output logic                 head_valid,
	output rti_pkg::entry_t      head,
	input  wire logic            pop
);
	import rti_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	entry_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	entry_t           ent;
	logic             push;

	always_comb begin
		ent.v0 = tri_in.v0;
		ent.n  = tri_in.n;
		for (int i = 0; i < 3; i++) begin
			ent.u[i]   = ssub(tri_in.v1[i], tri_in.v0[i]);
			ent.v[i]   = ssub(tri_in.v2[i], tri_in.v0[i]);
			ent.tmp[i] = ssub(tri_in.v0[i], ray.org[i]);
		end
	end

	assign in_ready   = cnt_q != (PTR_W+1)'(FIFO_DEPTH);
	assign push       = in_valid && in_ready;
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/rti_back.sv */
// Back end: plane test, barycentric solve and classification, one stalled-together pipeline.
// Depends on rti_pkg, rti_qmul and rti_qdiv.
`default_nettype none
module rti_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rti_pkg::ray_t              ray,
	input  wire logic                       head_valid,
	input  wire rti_pkg::entry_t            head,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            hit,
	output rti_pkg::reason_t                miss_reason,
	output logic [rti_pkg::DIST_W-1:0]      distance
);
	import rti_pkg::*;

	localparam int    CTX_W = $bits(ctx_t);
	localparam word_t ONE   = word_t'(1) <<< FRAC_BITS;

	logic adv;

	logic            vld_s1;
	entry_t          ent_s1;
	ctx_t            c1;
	word_t [14:0]    m1_a, m1_b, m1_p;
	logic            m1_vld;
	logic [CTX_W-1:0] m1_side;
	ctx_t            m1_ctx, c2, ctx_s2;
	logic            vld_s2;

	word_t [0:0]     d1_q;
	logic            d1_vld;
	logic [CTX_W-1:0] d1_side;
	ctx_t            d1_ctx, c3, ctx_s3;
	logic            vld_s3;

	word_t [4:0]     m2_a, m2_b, m2_p;
	logic            m2_vld;
	logic [CTX_W-1:0] m2_side;
	ctx_t            m2_ctx, c4, ctx_s4, c5, ctx_s5;
	logic            vld_s4, vld_s5;

	word_t [5:0]     m3_a, m3_b, m3_p;
	logic            m3_vld;
	logic [CTX_W-1:0] m3_side;
	ctx_t            m3_ctx, c6, ctx_s6;
	logic            vld_s6;

	word_t [3:0]     m4_a, m4_b, m4_p;
	logic            m4_vld;
	logic [CTX_W-1:0] m4_side;
	ctx_t            m4_ctx, c7, ctx_s7;
	logic            vld_s7;

	word_t [1:0]     d2_a, d2_b, d2_q;
	logic            d2_vld;
	logic [CTX_W-1:0] d2_side;
	ctx_t            d2_ctx;

	reason_t         rsn;
	word_t           s_val, t_val;
	logic            out_valid_q, hit_q;
	reason_t         reason_q;
	logic [DIST_W-1:0] dist_q;

	// The whole pipeline moves as one whenever the output register can take a word.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= head_valid;
			vld_s2      <= m1_vld;
			vld_s3      <= d1_vld;
			vld_s4      <= m2_vld;
			vld_s5      <= vld_s4;
			vld_s6      <= m3_vld;
			vld_s7      <= m4_vld;
			out_valid_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1   <= head;
			ctx_s2   <= c2;
			ctx_s3   <= c3;
			ctx_s4   <= c4;
			ctx_s5   <= c5;
			ctx_s6   <= c6;
			ctx_s7   <= c7;
			hit_q    <= rsn == RSN_HIT;
			reason_q <= rsn;
			dist_q   <= (rsn != RSN_HIT) ? '0 :
				(d2_ctx.r > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : d2_ctx.r[DIST_W-1:0];
		end
	end

	// Inner products n.d, n.(v0 - o), u.v, v.v and u.u.
	always_comb begin
		c1    = '0;
		c1.v0 = ent_s1.v0;
		c1.u  = ent_s1.u;
		c1.v  = ent_s1.v;
		for (int i = 0; i < 3; i++) begin
			m1_a[i]      = ent_s1.n[i];
			m1_b[i]      = ray.dir[i];
			m1_a[3 + i]  = ent_s1.n[i];
			m1_b[3 + i]  = ent_s1.tmp[i];
			m1_a[6 + i]  = ent_s1.u[i];
			m1_b[6 + i]  = ent_s1.v[i];
			m1_a[9 + i]  = ent_s1.v[i];
			m1_b[9 + i]  = ent_s1.v[i];
			m1_a[12 + i] = ent_s1.u[i];
			m1_b[12 + i] = ent_s1.u[i];
		end
	end

	rti_qmul #(.LANES(15), .FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_mul1 (
		.clk, .arst_n, .en(adv), .vld_in(vld_s1), .a(m1_a), .b(m1_b), .side_in(c1),
		.vld_out(m1_vld), .p(m1_p), .side_out(m1_side)
	);

	assign m1_ctx = ctx_t'(m1_side);

	always_comb begin
		c2     = m1_ctx;
		c2.den = sum3(m1_p[0], m1_p[1], m1_p[2]);
		c2.num = sum3(m1_p[3], m1_p[4], m1_p[5]);
		c2.uv  = sum3(m1_p[6], m1_p[7], m1_p[8]);
		c2.vv  = sum3(m1_p[9], m1_p[10], m1_p[11]);
		c2.uu  = sum3(m1_p[12], m1_p[13], m1_p[14]);
		c2.par = (c2.den == '0) || (word_t'(umag(c2.den)) < ray.tol);
	end

	// Ray parameter r; a parallel item divides by whatever den holds and ends as a miss.
	rti_qdiv #(.LANES(1), .FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_div1 (
		.clk, .arst_n, .en(adv), .vld_in(vld_s2), .a(ctx_s2.num), .b(ctx_s2.den),
		.side_in(ctx_s2), .vld_out(d1_vld), .q(d1_q), .side_out(d1_side)
	);

	assign d1_ctx = ctx_t'(d1_side);

	always_comb begin
		c3     = d1_ctx;
		c3.r   = d1_q[0];
		c3.beh = (c3.r <= 0) || (c3.r < ray.tol);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m2_a[i] = ctx_s3.r;
			m2_b[i] = ray.dir[i];
		end
		m2_a[3] = ctx_s3.uv;
		m2_b[3] = ctx_s3.uv;
		m2_a[4] = ctx_s3.uu;
		m2_b[4] = ctx_s3.vv;
	end

	rti_qmul #(.LANES(5), .FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_mul2 (
		.clk, .arst_n, .en(adv), .vld_in(vld_s3), .a(m2_a), .b(m2_b), .side_in(ctx_s3),
		.vld_out(m2_vld), .p(m2_p), .side_out(m2_side)
	);

	assign m2_ctx = ctx_t'(m2_side);

	// Hit point and the denominator of the barycentric solve.
	always_comb begin
		c4 = m2_ctx;
		for (int i = 0; i < 3; i++)
			c4.p[i] = sadd(ray.org[i], m2_p[i]);
		c4.d   = ssub(m2_p[3], m2_p[4]);
		c4.deg = c4.d == '0;
	end

	always_comb begin
		c5 = ctx_s4;
		for (int i = 0; i < 3; i++)
			c5.w[i] = ssub(ctx_s4.p[i], ctx_s4.v0[i]);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m3_a[i]     = ctx_s5.w[i];
			m3_b[i]     = ctx_s5.v[i];
			m3_a[3 + i] = ctx_s5.w[i];
			m3_b[3 + i] = ctx_s5.u[i];
		end
	end

	rti_qmul #(.LANES(6), .FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_mul3 (
		.clk, .arst_n, .en(adv), .vld_in(vld_s5), .a(m3_a), .b(m3_b), .side_in(ctx_s5),
		.vld_out(m3_vld), .p(m3_p), .side_out(m3_side)
	);

	assign m3_ctx = ctx_t'(m3_side);

	always_comb begin
		c6    = m3_ctx;
		c6.wv = sum3(m3_p[0], m3_p[1], m3_p[2]);
		c6.wu = sum3(m3_p[3], m3_p[4], m3_p[5]);
	end

	always_comb begin
		m4_a[0] = ctx_s6.uv;
		m4_b[0] = ctx_s6.wv;
		m4_a[1] = ctx_s6.vv;
		m4_b[1] = ctx_s6.wu;
		m4_a[2] = ctx_s6.uv;
		m4_b[2] = ctx_s6.wu;
		m4_a[3] = ctx_s6.uu;
		m4_b[3] = ctx_s6.wv;
	end

	rti_qmul #(.LANES(4), .FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_mul4 (
		.clk, .arst_n, .en(adv), .vld_in(vld_s6), .a(m4_a), .b(m4_b), .side_in(ctx_s6),
		.vld_out(m4_vld), .p(m4_p), .side_out(m4_side)
	);

	assign m4_ctx = ctx_t'(m4_side);

	always_comb begin
		c7      = m4_ctx;
		c7.snum = ssub(m4_p[0], m4_p[1]);
		c7.tnum = ssub(m4_p[2], m4_p[3]);
	end

	assign d2_a[0] = ctx_s7.snum;
	assign d2_a[1] = ctx_s7.tnum;
	assign d2_b[0] = ctx_s7.d;
	assign d2_b[1] = ctx_s7.d;

	rti_qdiv #(.LANES(2), .FRAC_BITS(FRAC_BITS), .SIDE_W(CTX_W)) u_div2 (
		.clk, .arst_n, .en(adv), .vld_in(vld_s7), .a(d2_a), .b(d2_b), .side_in(ctx_s7),
		.vld_out(d2_vld), .q(d2_q), .side_out(d2_side)
	);

	assign d2_ctx = ctx_t'(d2_side);
	assign s_val  = d2_q[0];
	assign t_val  = d2_q[1];

	// The earliest failing test names the miss.
	always_comb begin
		if (d2_ctx.par)
			rsn = RSN_PARALLEL;
		else if (d2_ctx.beh)
			rsn = RSN_BEHIND;
		else if (d2_ctx.deg)
			rsn = RSN_DEGEN;
		else if ((s_val < -ray.tol) || (t_val < -ray.tol) || (sadd(s_val, t_val) > ONE + ray.tol))
			rsn = RSN_OUTSIDE;
		else
			rsn = RSN_HIT;
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign miss_reason = reason_q;
	assign distance    = dist_q;

endmodule
`default_nettype wire

/* rtl/ray_triangle_intersect.sv */
// Top level of the ray/triangle intersection block: ray registers, front queue and back pipeline.
// Depends on rti_pkg, rti_front and rti_back (which uses rti_qmul and rti_qdiv).
//
//  Port group   Direction  Handshake              Carries
//  cfg_*        in         cfg_we (no wait)       one ray register per write, index 0..6
//  vert*/normal in         in_valid / in_ready    one triangle word per transfer
//  hit/...      out        out_valid / out_ready  one result word per triangle
//
// A triangle word is accepted every cycle while the four-entry front queue has room; its
// result passes through the two pipelined dividers (one quotient bit per stage) and the
// multiplier stages between them.
// Reset clears the queue, the pipeline valid bits and loads the default ray.
// A stalled output freezes the back pipeline only; the front keeps filling its queue.
`default_nettype none
module ray_triangle_intersect #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [COORD_WIDTH-1:0]            cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]     vert0_x,
	input  wire logic signed [COORD_WIDTH-1:0]     vert0_y,
	input  wire logic signed [COORD_WIDTH-1:0]     vert0_z,
	input  wire logic signed [COORD_WIDTH-1:0]     vert1_x,
	input  wire logic signed [COORD_WIDTH-1:0]     vert1_y,
	input  wire logic signed [COORD_WIDTH-1:0]     vert1_z,
	input  wire logic signed [COORD_WIDTH-1:0]     vert2_x,
	input  wire logic signed [COORD_WIDTH-1:0]     vert2_y,
	input  wire logic signed [COORD_WIDTH-1:0]     vert2_z,
	input  wire logic signed [COORD_WIDTH-1:0]     normal_x,
	input  wire logic signed [COORD_WIDTH-1:0]     normal_y,
	input  wire logic signed [COORD_WIDTH-1:0]     normal_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   hit,
	output logic [2:0]                             miss_reason,
	output logic [rti_pkg::DIST_W-1:0]             distance
);
	import rti_pkg::*;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// Default direction is one unit along x.
	localparam coord_t DIR_X_RST = coord_t'(1) <<< FRAC_BITS;

	coord_t             org_q [3];
	coord_t             dir_q [3];
	logic [TOL_W-1:0]   tol_q;
	ray_t               ray;
	tri_t               tri_in;
	logic               head_valid, pop;
	entry_t             head;
	reason_t            rsn;

	// Ray registers; the user writes only while the block is idle (unenforced); spare index ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= DIR_X_RST;
			dir_q[1] <= '0;
			dir_q[2] <= '0;
			tol_q    <= TOL_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORG_X: org_q[0] <= cfg_data;
				REG_ORG_Y: org_q[1] <= cfg_data;
				REG_ORG_Z: org_q[2] <= cfg_data;
				REG_DIR_X: dir_q[0] <= cfg_data;
				REG_DIR_Y: dir_q[1] <= cfg_data;
				REG_DIR_Z: dir_q[2] <= cfg_data;
				REG_TOL:   tol_q    <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Everything inside works on 64-bit words; coordinates sign-extend, tolerance zero-extends.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ray.org[i] = word_t'(org_q[i]);
			ray.dir[i] = word_t'(dir_q[i]);
		end
		ray.tol = word_t'(tol_q);

		tri_in.v0[0] = word_t'(vert0_x);
		tri_in.v0[1] = word_t'(vert0_y);
		tri_in.v0[2] = word_t'(vert0_z);
		tri_in.v1[0] = word_t'(vert1_x);
		tri_in.v1[1] = word_t'(vert1_y);
		tri_in.v1[2] = word_t'(vert1_z);
		tri_in.v2[0] = word_t'(vert2_x);
		tri_in.v2[1] = word_t'(vert2_y);
		tri_in.v2[2] = word_t'(vert2_z);
		tri_in.n[0]  = word_t'(normal_x);
		tri_in.n[1]  = word_t'(normal_y);
		tri_in.n[2]  = word_t'(normal_z);
	end

	rti_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .tri_in, .ray,
		.head_valid, .head, .pop
	);

	rti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .ray, .head_valid, .head, .pop,
		.out_valid, .out_ready, .hit, .miss_reason(rsn), .distance
	);

	assign miss_reason = rsn;

endmodule
`default_nettype wire

/* rtl/rti_checker.sv */
// Port-level checks on the result channel of the ray/triangle intersection block.
// Depends on rti_pkg; bound to ray_triangle_intersect at the end of this file.
`default_nettype none
module rti_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic                          hit,
	input  wire logic [2:0]                    miss_reason,
	input  wire logic [rti_pkg::DIST_W-1:0]    distance
);
	import rti_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hit) && $stable(miss_reason) && $stable(distance))
		else $error("result word changed while stalled");

	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit == (miss_reason == RSN_HIT))
		else $error("hit flag disagrees with miss reason");

	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> distance == '0)
		else $error("distance not zero on a miss");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
	.clk, .arst_n, .out_valid, .out_ready, .hit, .miss_reason, .distance
);
`default_nettype wire
